>>> rtl/tpm_pkg.sv
`default_nettype none
package tpm_pkg;

    localparam int TIME_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_BITS  = 2 * TIME_BITS;
    localparam int SHIFT_BITS = PROD_BITS - FRAC_BITS;
    localparam int DIV_STAGES = TIME_BITS;
    localparam int ADDR_BITS  = 5;
    localparam int IDX_BITS   = 3;
    localparam int DATA_BITS  = 32;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_CLAMP  = 2'd0;
    localparam t_mode MODE_WRAP   = 2'd1;
    localparam t_mode MODE_MIRROR = 2'd2;

    typedef logic [IDX_BITS-1:0] t_reg_idx;
    localparam t_reg_idx REG_MODE  = 3'd0;
    localparam t_reg_idx REG_MIN   = 3'd1;
    localparam t_reg_idx REG_MAX   = 3'd2;
    localparam t_reg_idx REG_PHASE = 3'd3;
    localparam t_reg_idx REG_RATE  = 3'd4;

    localparam logic [TIME_BITS-1:0] RATE_RESET = TIME_BITS'(65536);

    // per-item control that rides along the divider stages
    typedef struct packed {
        logic                 clamp;
        logic                 mirror;
        logic                 range_pos;
        logic                 neg;
        logic [TIME_BITS-1:0] clamp_res;
    } t_ctl;

endpackage
`default_nettype wire

>>> rtl/tpm_scale.sv
`default_nettype none
module tpm_scale (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_valid,
    input  wire logic signed [tpm_pkg::TIME_BITS-1:0] i_app_time,
    input  wire tpm_pkg::t_mode                      i_mode,
    input  wire logic signed [tpm_pkg::TIME_BITS-1:0] i_min_time,
    input  wire logic signed [tpm_pkg::TIME_BITS-1:0] i_max_time,
    input  wire logic signed [tpm_pkg::TIME_BITS-1:0] i_phase_offset,
    input  wire logic signed [tpm_pkg::TIME_BITS-1:0] i_rate_scale,
    input  wire logic                                i_range_pos,
    output logic                                     o_valid,
    output tpm_pkg::t_ctl                            o_ctl,
    output logic [tpm_pkg::TIME_BITS-1:0]            o_mag
);
    localparam int TB = tpm_pkg::TIME_BITS;
    localparam int SB = tpm_pkg::SHIFT_BITS;

    logic                                     r1_v;
    logic signed [tpm_pkg::PROD_BITS-1:0]     r1_prod;
    logic                                     r2_v;
    logic signed [TB-1:0]                     r2_t;
    logic                                     r3_v;
    tpm_pkg::t_ctl                            r3_ctl;
    logic [TB-1:0]                            r3_mag;

    logic [SB-1:0]     w_shift;
    logic [SB:0]       w_sum;
    logic signed [TB-1:0] n_t;
    logic [TB:0]       w_d;
    logic [TB:0]       w_dneg;
    tpm_pkg::t_ctl     n_ctl;

    // dropping the low product bits of a signed value floors it
    assign w_shift = r1_prod[tpm_pkg::PROD_BITS-1:tpm_pkg::FRAC_BITS];
    assign w_sum   = {w_shift[SB-1], w_shift}
                   + {{(SB + 1 - TB){i_phase_offset[TB-1]}}, i_phase_offset};

    always_comb begin
        if (&w_sum[SB:TB-1] || ~|w_sum[SB:TB-1]) begin
            n_t = w_sum[TB-1:0];
        end else if (w_sum[SB]) begin
            n_t = {1'b1, {(TB-1){1'b0}}};
        end else begin
            n_t = {1'b0, {(TB-1){1'b1}}};
        end
    end

    assign w_d    = {r2_t[TB-1], r2_t} - {i_min_time[TB-1], i_min_time};
    assign w_dneg = -w_d;

    always_comb begin
        n_ctl.clamp     = (i_mode == tpm_pkg::MODE_CLAMP);
        n_ctl.mirror    = (i_mode != tpm_pkg::MODE_CLAMP) && (i_mode != tpm_pkg::MODE_WRAP);
        n_ctl.range_pos = i_range_pos;
        n_ctl.neg       = w_d[TB];
        if (r2_t < i_min_time) begin
            n_ctl.clamp_res = i_min_time;
        end else if (r2_t > i_max_time) begin
            n_ctl.clamp_res = i_max_time;
        end else begin
            n_ctl.clamp_res = r2_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= tpm_pkg::PROD_BITS'(i_rate_scale) * tpm_pkg::PROD_BITS'(i_app_time);
            r2_t    <= n_t;
            r3_ctl  <= n_ctl;
            r3_mag  <= w_d[TB] ? w_dneg[TB-1:0] : w_d[TB-1:0];
        end
    end

    assign o_valid = r3_v;
    assign o_ctl   = r3_ctl;
    assign o_mag   = r3_mag;

endmodule
`default_nettype wire

>>> rtl/tpm_divider.sv
`default_nettype none
module tpm_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire tpm_pkg::t_ctl                 i_ctl,
    input  wire logic [tpm_pkg::TIME_BITS-1:0] i_mag,
    input  wire logic [tpm_pkg::TIME_BITS-1:0] i_range,
    output logic                               o_valid,
    output tpm_pkg::t_ctl                      o_ctl,
    output logic [tpm_pkg::TIME_BITS-1:0]      o_rem,
    output logic                               o_q_odd
);
    localparam int TB = tpm_pkg::TIME_BITS;
    localparam int DS = tpm_pkg::DIV_STAGES;

    logic          r_v   [DS];
    tpm_pkg::t_ctl r_c   [DS];
    logic [TB-1:0] r_rem [DS];
    logic [TB-1:0] r_dvd [DS];
    logic          r_q   [DS];

    // restoring division, one quotient bit per stage; only the last bit is kept
    for (genvar k = 0; k < DS; k++) begin : g_stage
        logic          w_v;
        tpm_pkg::t_ctl w_c;
        logic [TB-1:0] w_rem;
        logic [TB-1:0] w_dvd;
        logic [TB:0]   w_trial;
        logic [TB:0]   w_diff;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_c   = i_ctl;
            assign w_rem = '0;
            assign w_dvd = i_mag;
        end else begin : g_next
            assign w_v   = r_v[k-1];
            assign w_c   = r_c[k-1];
            assign w_rem = r_rem[k-1];
            assign w_dvd = r_dvd[k-1];
        end

        assign w_trial = {w_rem, w_dvd[TB-1]};
        assign w_diff  = w_trial - {1'b0, i_range};
        assign w_ge    = !w_diff[TB];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_c[k]   <= w_c;
                r_rem[k] <= w_ge ? w_diff[TB-1:0] : w_trial[TB-1:0];
                r_dvd[k] <= {w_dvd[TB-2:0], 1'b0};
                r_q[k]   <= w_ge;
            end
        end
    end

    assign o_valid = r_v[DS-1];
    assign o_ctl   = r_c[DS-1];
    assign o_rem   = r_rem[DS-1];
    assign o_q_odd = r_q[DS-1];

endmodule
`default_nettype wire

>>> rtl/time_repeat_mapper.sv
// time_repeat_mapper: maps a signed Q16.16 application time to a controller time.
// Input channel: i_valid / o_stall with i_app_time; an item is taken at a rising
// edge with i_valid high and o_stall low. Output channel: o_valid / i_stall with
// o_control_time; a result is taken at an edge with o_valid high and i_stall low.
// Configuration goes through the APB-style port (byte address 4 * register index:
// mode, min, max, phase, rate); pready is always high and prdata reads back.
// Write configuration only while no item is in flight.
// The pipeline has 36 register stages: multiply, phase add and saturate, clamp and
// offset from min, 32 restoring divider stages (one quotient bit each) and the
// output register. One item is taken every cycle while o_stall is low.
// Reset (synchronous, active low) empties the pipeline and sets mode clamp,
// min, max and phase to zero and rate to 1.0.
// When the receiver stalls a waiting result, the whole pipeline holds and
// o_stall rises in the same cycle; nothing is dropped or repeated.
`default_nettype none
module time_repeat_mapper (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic signed [tpm_pkg::TIME_BITS-1:0] i_app_time,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [tpm_pkg::TIME_BITS-1:0]      o_control_time,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [tpm_pkg::ADDR_BITS-1:0]        paddr,
    input  wire logic [tpm_pkg::DATA_BITS-1:0]        pwdata,
    output logic [tpm_pkg::DATA_BITS-1:0]             prdata,
    output logic                                      pready
);
    localparam int TB = tpm_pkg::TIME_BITS;

    tpm_pkg::t_mode       r_mode;
    logic signed [TB-1:0] r_min_time;
    logic signed [TB-1:0] r_max_time;
    logic signed [TB-1:0] r_phase_offset;
    logic signed [TB-1:0] r_rate_scale;

    logic                 r_out_valid;
    logic signed [TB-1:0] r_out_time;

    logic                 w_en;
    logic                 w_wr;
    tpm_pkg::t_reg_idx    w_idx;
    logic [TB:0]          w_range;
    logic                 w_range_pos;

    logic                 w_s_valid;
    tpm_pkg::t_ctl        w_s_ctl;
    logic [TB-1:0]        w_s_mag;
    logic                 w_d_valid;
    tpm_pkg::t_ctl        w_d_ctl;
    logic [TB-1:0]        w_d_rem;
    logic                 w_d_q_odd;

    logic [TB-1:0]        w_r;
    logic                 w_odd;
    logic [TB-1:0]        n_out_time;

    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_out_valid;
    assign o_control_time = r_out_time;
    assign pready  = 1'b1;

    assign w_wr  = psel && penable && pwrite;
    assign w_idx = paddr[tpm_pkg::ADDR_BITS-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= tpm_pkg::MODE_CLAMP;
            r_min_time     <= '0;
            r_max_time     <= '0;
            r_phase_offset <= '0;
            r_rate_scale   <= tpm_pkg::RATE_RESET;
        end else if (w_wr) begin
            case (w_idx)
                tpm_pkg::REG_MODE:  r_mode         <= pwdata[1:0];
                tpm_pkg::REG_MIN:   r_min_time     <= pwdata[TB-1:0];
                tpm_pkg::REG_MAX:   r_max_time     <= pwdata[TB-1:0];
                tpm_pkg::REG_PHASE: r_phase_offset <= pwdata[TB-1:0];
                tpm_pkg::REG_RATE:  r_rate_scale   <= pwdata[TB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            tpm_pkg::REG_MODE:  prdata = {{(tpm_pkg::DATA_BITS-2){1'b0}}, r_mode};
            tpm_pkg::REG_MIN:   prdata = r_min_time;
            tpm_pkg::REG_MAX:   prdata = r_max_time;
            tpm_pkg::REG_PHASE: prdata = r_phase_offset;
            tpm_pkg::REG_RATE:  prdata = r_rate_scale;
            default:            prdata = '0;
        endcase
    end

    assign w_range     = {r_max_time[TB-1], r_max_time} - {r_min_time[TB-1], r_min_time};
    assign w_range_pos = !w_range[TB] && (|w_range[TB-1:0]);

    tpm_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_valid),
        .i_app_time     (i_app_time),
        .i_mode         (r_mode),
        .i_min_time     (r_min_time),
        .i_max_time     (r_max_time),
        .i_phase_offset (r_phase_offset),
        .i_rate_scale   (r_rate_scale),
        .i_range_pos    (w_range_pos),
        .o_valid        (w_s_valid),
        .o_ctl          (w_s_ctl),
        .o_mag          (w_s_mag)
    );

    tpm_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_valid),
        .i_ctl   (w_s_ctl),
        .i_mag   (w_s_mag),
        .i_range (w_range[TB-1:0]),
        .o_valid (w_d_valid),
        .o_ctl   (w_d_ctl),
        .o_rem   (w_d_rem),
        .o_q_odd (w_d_q_odd)
    );

    // floor correction for a negative offset from min
    always_comb begin
        if (w_d_ctl.neg && (|w_d_rem)) begin
            w_r   = w_range[TB-1:0] - w_d_rem;
            w_odd = !w_d_q_odd;
        end else begin
            w_r   = w_d_rem;
            w_odd = w_d_q_odd;
        end
        if (w_d_ctl.clamp) begin
            n_out_time = w_d_ctl.clamp_res;
        end else if (!w_d_ctl.range_pos) begin
            n_out_time = r_min_time;
        end else if (w_d_ctl.mirror && w_odd) begin
            n_out_time = r_max_time - w_r;
        end else begin
            n_out_time = r_min_time + w_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_time <= n_out_time;
        end
    end

    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(w_d_valid) && $stable(w_d_rem))
        else $error("divider output moved while stalled");

    a_empty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_d_valid && !w_d_ctl.clamp && !w_d_ctl.range_pos)
        |=> o_control_time == r_min_time)
        else $error("non-positive range did not give min_time");

    a_wrap_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_d_valid && !w_d_ctl.clamp && !w_d_ctl.mirror && w_d_ctl.range_pos)
        |=> (o_control_time >= r_min_time) && (o_control_time < r_max_time))
        else $error("wrapped time outside [min, max)");

    a_rem_below_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_d_valid && w_d_ctl.range_pos) |-> (w_d_rem < w_range[TB-1:0]))
        else $error("divider remainder not below range");

endmodule
`default_nettype wire

>>> dv/time_repeat_mapper_checker.sv
module time_repeat_mapper_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    input  wire logic                                 o_stall,
    input  wire logic signed [tpm_pkg::TIME_BITS-1:0] i_app_time,
    input  wire logic                                 o_valid,
    input  wire logic                                 i_stall,
    input  wire logic signed [tpm_pkg::TIME_BITS-1:0] o_control_time,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic                                 pready,
    input  wire logic [tpm_pkg::ADDR_BITS-1:0]        paddr,
    input  wire logic [tpm_pkg::DATA_BITS-1:0]        pwdata,
    output int                                        o_fail_count,
    output int                                        o_pending,
    output int                                        o_result_count
);
    import tpm_pkg::*;

    localparam longint TMAX = 64'sd2147483647;
    localparam longint TMIN = -64'sd2147483648;

    t_mode  mode_q;
    longint lo_bound, hi_bound, phase_q, rate_q;
    logic signed [TIME_BITS-1:0] time_fifo[$];

    // floor(rate * app / 2^16) + phase, saturated to the time range
    function automatic longint scaled_time(longint app);
        logic signed [127:0] prod;
        longint t;
        begin
            prod = (128'(signed'(rate_q)) * 128'(signed'(app))) >>> FRAC_BITS;
            if (prod > 128'sd4503599627370496) prod = 128'sd4503599627370496;
            if (prod < -128'sd4503599627370496) prod = -128'sd4503599627370496;
            t = longint'(prod) + phase_q;
            if (t > TMAX) t = TMAX;
            if (t < TMIN) t = TMIN;
            return t;
        end
    endfunction

    function automatic logic signed [TIME_BITS-1:0] mapped_time(longint app);
        longint t, span, d, q, r, res;
        begin
            t = scaled_time(app);
            if (mode_q == MODE_CLAMP) begin
                if (t < lo_bound) res = lo_bound;
                else if (t > hi_bound) res = hi_bound;
                else res = t;
            end else begin
                span = hi_bound - lo_bound;
                if (span > 0) begin
                    d = t - lo_bound;
                    q = d / span;
                    r = d % span;
                    if (r < 0) begin
                        r += span;
                        q -= 1;
                    end
                    // mode 3 behaves like mirror
                    if (mode_q != MODE_WRAP && q[0]) res = hi_bound - r;
                    else res = lo_bound + r;
                end else begin
                    res = lo_bound;
                end
            end
            return res[TIME_BITS-1:0];
        end
    endfunction

    assign o_pending = time_fifo.size();

    always @(posedge i_clk) begin
        logic signed [TIME_BITS-1:0] want;
        if (!i_rst_n) begin
            mode_q   <= MODE_CLAMP;
            lo_bound <= 0;
            hi_bound <= 0;
            phase_q  <= 0;
            rate_q   <= 65536;
            o_fail_count   <= 0;
            o_result_count <= 0;
            time_fifo.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr >> 2))
                    REG_MODE:  mode_q   <= t_mode'(pwdata[1:0]);
                    REG_MIN:   lo_bound <= longint'(signed'(pwdata));
                    REG_MAX:   hi_bound <= longint'(signed'(pwdata));
                    REG_PHASE: phase_q  <= longint'(signed'(pwdata));
                    REG_RATE:  rate_q   <= longint'(signed'(pwdata));
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                time_fifo.push_back(mapped_time(longint'(i_app_time)));
            if (o_valid && !i_stall) begin
                o_result_count <= o_result_count + 1;
                if (time_fifo.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, o_control_time);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = time_fifo.pop_front();
                    if (want !== o_control_time) begin
                        $display("%0t: control_time expected %0d actual %0d",
                                 $time, want, o_control_time);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> dv/time_repeat_mapper_tb.sv
module time_repeat_mapper_tb;
    import tpm_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_stall = 0;
    logic signed [TIME_BITS-1:0] i_app_time = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_BITS-1:0] paddr = 0;
    logic [DATA_BITS-1:0] pwdata = 0;
    logic o_stall, o_valid, pready;
    logic signed [TIME_BITS-1:0] o_control_time;
    logic [DATA_BITS-1:0] prdata;
    int fail_count, pending, result_count;
    int item_count = 0;
    bit hold_off = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    time_repeat_mapper dut (.*);

    time_repeat_mapper_checker checker_inst (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_app_time, .o_valid, .i_stall,
        .o_control_time, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    function automatic logic [31:0] edgy_time();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 16'hffff) << 16;
            3: return 32'($signed($urandom_range(0, 65535)) - 32768);
            4: return 32'($signed($urandom_range(0, 20'hfffff)) - 20'h80000);
            default: return $urandom;
        endcase
    endfunction

    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= ADDR_BITS'(idx) << 2;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        @(negedge i_clk);
    endtask

    // valid stays high after the item so back to back items need no gap;
    // drain() drops it
    task automatic send_item(logic [31:0] val, bit idle_gaps);
        int g;
        g = 0;
        if (idle_gaps) begin
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        end
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1;
        i_app_time <= val;
        do @(posedge i_clk); while (o_stall);
        item_count++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (45) @(negedge i_clk);
    endtask

    // receiver stall process
    initial begin
        int g;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_stall <= 1;
                repeat (150) @(negedge i_clk);
                i_stall <= 0;
                hold_off = 0;
            end else if ($urandom_range(0, 4) == 0) begin
                g = gap_len();
                if (g > 0) begin
                    i_stall <= 1;
                    repeat (g) @(negedge i_clk);
                    i_stall <= 0;
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        logic [31:0] dir_vals[12];
        int phase_no;
        dir_vals = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'hffff_0000,
                     32'h0000_0001, 32'hffff_ffff, 32'h0002_8000, 32'hfffd_8000,
                     32'h0005_0000, 32'hfffb_0000, 32'h0000_ffff};
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // directed: reset settings, then each mode with a positive range
        foreach (dir_vals[k]) send_item(dir_vals[k], 0);
        drain();
        reg_write(REG_MIN, 32'hffff_0000);
        reg_write(REG_MAX, 32'h0003_0000);
        reg_write(REG_PHASE, 32'h0000_8000);
        reg_write(REG_RATE, 32'hfffe_0000);
        for (int m = 0; m < 4; m++) begin
            reg_write(REG_MODE, 32'(m));
            for (int k = 0; k < 4; k++) send_item(dir_vals[k * 3 + m % 3], 0);
            drain();
        end
        // random phases, extremes of the register space included
        for (phase_no = 0; phase_no < 26; phase_no++) begin
            reg_write(REG_MODE, $urandom_range(0, 3));
            case (phase_no % 5)
                0: begin
                    reg_write(REG_MIN, 32'h8000_0000);
                    reg_write(REG_MAX, 32'h7fff_ffff);
                end
                1: begin
                    reg_write(REG_MIN, edgy_time());
                    reg_write(REG_MAX, edgy_time());
                end
                default: begin
                    reg_write(REG_MIN, 32'($signed($urandom_range(0, 20'hfffff)) - 20'h80000));
                    reg_write(REG_MAX, 32'($signed($urandom_range(0, 20'hfffff)) - 20'h30000));
                end
            endcase
            reg_write(REG_PHASE, edgy_time());
            reg_write(REG_RATE, (phase_no == 3) ? 32'h8000_0000 :
                                (phase_no == 4) ? 32'h7fff_ffff : edgy_time());
            if (phase_no == 7) hold_off = 1;
            repeat (50) send_item(edgy_time(), 1);
            drain();
        end
        $display("run covered %0d items and %0d results over 26 register settings",
                 item_count, result_count);
        $display("all four mode codes, bound and rate extremes, receiver hold-off");
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

>>> files.f
rtl/tpm_pkg.sv
rtl/tpm_scale.sv
rtl/tpm_divider.sv
rtl/time_repeat_mapper.sv
dv/time_repeat_mapper_checker.sv
dv/time_repeat_mapper_tb.sv
